// ===== rtl/hpcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcp_pkg
// Shared types, character codes and helper functions of the command parser.
// ----------------------------------------------------------------------------
package hpcp_pkg;

    // parse phase of the current command
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST,
        PH_PAIRS,
        PH_SINGLE,
        PH_INIT,
        PH_IGNORE
    } phase_t;

    // action codes of a result
    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_PRESS = 2'd2;
    localparam logic [1:0] ACT_SPEED = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    localparam logic [7:0] STEPS_PER_MM_RESET = 8'd40;

    // argument magnitude saturation
    localparam logic [23:0] NUM_MAX = 24'hFFFFFF;
    // saturation of value*steps_per_mm, far above the coordinate clamp point
    localparam logic [21:0] PROD_CAP = 22'h3FFFFF;
    // value*steps_per_mm at or above this scales past 65535
    localparam logic [21:0] SAT_PROD = 22'd2621440;
    // ceil(2^21/5), exact division by five for operands below 2^19
    localparam logic [18:0] RECIP_5 = 19'd419431;

    localparam logic [8:0] PRESS_PEN0  = 9'd300;
    localparam logic [8:0] PRESS_PEN1  = 9'd200;
    localparam logic [8:0] PRESS_PEN2  = 9'd100;
    localparam logic [8:0] PRESS_OTHER = 9'd50;
    localparam logic [8:0] PRESS_INIT  = 9'd200;
    localparam logic [8:0] SPEED_MAX   = 9'd100;
    localparam logic [8:0] SPEED_MIN   = 9'd10;
    localparam logic [23:0] SPEED_MIN_ARG = 24'd45;

    typedef struct packed {
        logic        last;
        logic [8:0]  amount;
        logic [15:0] y_steps;
        logic [15:0] x_steps;
        logic [1:0]  action;
    } result_t;

    // what one character produces: up to two results
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } emit_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    // prod = value*steps_per_mm (capped); returns prod/40 clamped to 65535
    function automatic logic [15:0] scale_coord(input logic [21:0] prod);
        logic [37:0] q;
        q = {19'd0, prod[21:3]} * {19'd0, RECIP_5};
        if (prod >= SAT_PROD) begin
            return 16'hFFFF;
        end
        return q[36:21];
    endfunction

endpackage

// ===== rtl/hpcp_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcp_result_fifo
// Four-entry result queue; takes up to two results a cycle, gives one on ready.
// ----------------------------------------------------------------------------
module hpcp_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  hpcp_pkg::emit_t   push,
    input  logic              push_en,
    output logic              room_two,
    output logic              out_valid,
    input  logic              out_ready,
    output hpcp_pkg::result_t out_data
);

    hpcp_pkg::result_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_n;
    logic       pop;

    assign push_n    = push_en ? push.count : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room_two  = (count_reg <= 3'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

endmodule

// ===== rtl/hpcp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcp_core
// Command state and its registered update for one received character.
// ----------------------------------------------------------------------------
module hpcp_core #(
    parameter int MAX_COMMAND_LEN = 256
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic [7:0]      char_code,
    input  logic [7:0]      steps_per_mm,
    output hpcp_pkg::emit_t emit
);

    localparam int CNT_W = $clog2(MAX_COMMAND_LEN);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_COMMAND_LEN - 1);

    hpcp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       op_first_reg, op_first_next;
    logic [7:0]       op_second_reg, op_second_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [23:0]      value_reg, value_next;
    logic [21:0]      prod_reg, prod_next;
    logic             negative_reg, negative_next;
    logic             active_reg, active_next;
    logic             half_reg, half_next;
    logic [15:0]      held_x_reg, held_x_next;
    logic             stopped_reg, stopped_next;

    logic        is_term, is_blank, is_sep, is_sign, is_digit, taken, terminating;
    logic [7:0]  ch_up;
    logic [3:0]  digit;
    logic [23:0] base_v, acc_v;
    logic [21:0] base_p, acc_p;
    logic [27:0] v10;
    logic [25:0] p10;
    logic [11:0] dmul;
    logic [15:0] scaled_cur;
    logic        neg_nonzero;
    logic [1:0]  coord_action;
    logic [8:0]  press_amount, speed_amount;

    assign is_term  = (char_code == hpcp_pkg::CH_SEMI) || (char_code == hpcp_pkg::CH_CR) ||
                      (char_code == hpcp_pkg::CH_LF);
    assign is_blank = (char_code == hpcp_pkg::CH_SPACE) || (char_code == hpcp_pkg::CH_TAB);
    assign is_sep   = is_blank || (char_code == hpcp_pkg::CH_COMMA);
    assign is_sign  = (char_code == hpcp_pkg::CH_PLUS) || (char_code == hpcp_pkg::CH_MINUS);
    assign is_digit = (char_code >= hpcp_pkg::CH_ZERO) && (char_code <= hpcp_pkg::CH_NINE);
    assign digit    = char_code[3:0];
    assign ch_up    = hpcp_pkg::to_upper(char_code);
    assign terminating = fire && is_term && (count_reg != '0);
    assign taken    = fire && !is_term && (count_reg < CNT_LIMIT);

    // in the pairs phase a digit after a finished argument starts from zero
    assign base_v = (active_reg || phase_reg == hpcp_pkg::PH_SINGLE) ? value_reg : 24'd0;
    assign base_p = (active_reg || phase_reg == hpcp_pkg::PH_SINGLE) ? prod_reg : 22'd0;
    assign dmul   = {8'd0, digit} * {4'd0, steps_per_mm};
    assign v10    = ({4'd0, base_v} << 3) + ({4'd0, base_v} << 1) + {24'd0, digit};
    assign p10    = ({4'd0, base_p} << 3) + ({4'd0, base_p} << 1) + {14'd0, dmul};
    assign acc_v  = (v10 > {4'd0, hpcp_pkg::NUM_MAX}) ? hpcp_pkg::NUM_MAX : v10[23:0];
    assign acc_p  = (p10[25:22] != 4'd0) ? hpcp_pkg::PROD_CAP : p10[21:0];

    assign scaled_cur   = negative_reg ? 16'd0 : hpcp_pkg::scale_coord(prod_reg);
    assign coord_action = (op_second_reg == hpcp_pkg::CH_D) ? hpcp_pkg::ACT_DRAW
                                                            : hpcp_pkg::ACT_MOVE;
    assign neg_nonzero  = negative_reg && (value_reg != 24'd0);

    always_comb begin
        if (neg_nonzero) begin
            press_amount = hpcp_pkg::PRESS_OTHER;
            speed_amount = hpcp_pkg::SPEED_MAX;
        end else begin
            priority case (value_reg)
                24'd0:   press_amount = hpcp_pkg::PRESS_PEN0;
                24'd1:   press_amount = hpcp_pkg::PRESS_PEN1;
                24'd2:   press_amount = hpcp_pkg::PRESS_PEN2;
                default: press_amount = hpcp_pkg::PRESS_OTHER;
            endcase
            if (value_reg >= hpcp_pkg::SPEED_MIN_ARG) begin
                speed_amount = hpcp_pkg::SPEED_MIN;
            end else begin
                speed_amount = hpcp_pkg::SPEED_MAX - {2'd0, value_reg[5:0], 1'b0};
            end
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (terminating) begin
            phase_next = hpcp_pkg::PH_IDLE;
        end else if (taken) begin
            unique case (phase_reg)
                hpcp_pkg::PH_IDLE: begin
                    if (!is_blank) begin
                        phase_next = (char_code == hpcp_pkg::CH_NUL) ? hpcp_pkg::PH_IGNORE
                                                                     : hpcp_pkg::PH_FIRST;
                    end
                end
                hpcp_pkg::PH_FIRST: begin
                    if (op_first_reg == hpcp_pkg::CH_I && ch_up == hpcp_pkg::CH_N) begin
                        phase_next = hpcp_pkg::PH_INIT;
                    end else if (op_first_reg == hpcp_pkg::CH_P &&
                                 (ch_up == hpcp_pkg::CH_U || ch_up == hpcp_pkg::CH_D)) begin
                        phase_next = hpcp_pkg::PH_PAIRS;
                    end else if ((op_first_reg == hpcp_pkg::CH_S && ch_up == hpcp_pkg::CH_P) ||
                                 (op_first_reg == hpcp_pkg::CH_V && ch_up == hpcp_pkg::CH_S)) begin
                        phase_next = hpcp_pkg::PH_SINGLE;
                    end else begin
                        phase_next = hpcp_pkg::PH_IGNORE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // argument datapath and results
    always_comb begin
        op_first_next  = op_first_reg;
        op_second_next = op_second_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        prod_next      = prod_reg;
        negative_next  = negative_reg;
        active_next    = active_reg;
        half_next      = half_reg;
        held_x_next    = held_x_reg;
        stopped_next   = stopped_reg;
        emit           = '0;

        if (terminating) begin
            unique case (phase_reg)
                hpcp_pkg::PH_PAIRS: begin
                    if (!stopped_reg && active_reg && half_reg) begin
                        emit.count          = 2'd1;
                        emit.first.action   = coord_action;
                        emit.first.x_steps  = held_x_reg;
                        emit.first.y_steps  = scaled_cur;
                        emit.first.last     = 1'b1;
                    end
                end
                hpcp_pkg::PH_INIT: begin
                    emit.count         = 2'd2;
                    emit.first.action  = hpcp_pkg::ACT_PRESS;
                    emit.first.amount  = hpcp_pkg::PRESS_INIT;
                    emit.second.action = hpcp_pkg::ACT_MOVE;
                    emit.second.last   = 1'b1;
                end
                hpcp_pkg::PH_SINGLE: begin
                    emit.count = 2'd1;
                    emit.first.last = 1'b1;
                    if (op_first_reg == hpcp_pkg::CH_S) begin
                        emit.first.action = hpcp_pkg::ACT_PRESS;
                        emit.first.amount = press_amount;
                    end else begin
                        emit.first.action = hpcp_pkg::ACT_SPEED;
                        emit.first.amount = speed_amount;
                    end
                end
                default: emit.count = 2'd0;
            endcase
            op_first_next  = 8'd0;
            op_second_next = 8'd0;
            count_next     = '0;
            value_next     = 24'd0;
            prod_next      = 22'd0;
            negative_next  = 1'b0;
            active_next    = 1'b0;
            half_next      = 1'b0;
            held_x_next    = 16'd0;
            stopped_next   = 1'b0;
        end else if (taken) begin
            count_next = count_reg + CNT_W'(1);
            unique case (phase_reg)
                hpcp_pkg::PH_IDLE: begin
                    if (!is_blank && char_code != hpcp_pkg::CH_NUL) begin
                        op_first_next = ch_up;
                    end
                end
                hpcp_pkg::PH_FIRST: begin
                    op_second_next = ch_up;
                    value_next     = 24'd0;
                    prod_next      = 22'd0;
                    negative_next  = 1'b0;
                    active_next    = 1'b0;
                    half_next      = 1'b0;
                    held_x_next    = 16'd0;
                    stopped_next   = 1'b0;
                end
                hpcp_pkg::PH_PAIRS: begin
                    if (!stopped_reg) begin
                        if (is_digit) begin
                            if (!active_reg) begin
                                negative_next = 1'b0;
                            end
                            active_next = 1'b1;
                            value_next  = acc_v;
                            prod_next   = acc_p;
                        end else begin
                            // any non-digit finishes the coordinate in progress
                            if (active_reg) begin
                                active_next = 1'b0;
                                if (!half_reg) begin
                                    held_x_next = scaled_cur;
                                    half_next   = 1'b1;
                                end else begin
                                    half_next          = 1'b0;
                                    emit.count         = 2'd1;
                                    emit.first.action  = coord_action;
                                    emit.first.x_steps = held_x_reg;
                                    emit.first.y_steps = scaled_cur;
                                    emit.first.last    = 1'b1;
                                end
                            end
                            if (is_sign) begin
                                active_next   = 1'b1;
                                value_next    = 24'd0;
                                prod_next     = 22'd0;
                                negative_next = (char_code == hpcp_pkg::CH_MINUS);
                            end else if (!is_sep) begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                hpcp_pkg::PH_SINGLE: begin
                    if (!stopped_reg) begin
                        if (is_digit) begin
                            active_next = 1'b1;
                            value_next  = acc_v;
                            prod_next   = acc_p;
                        end else if (is_sign) begin
                            if (active_reg) begin
                                stopped_next = 1'b1;
                            end else begin
                                active_next   = 1'b1;
                                negative_next = (char_code == hpcp_pkg::CH_MINUS);
                            end
                        end else if (is_sep) begin
                            if (active_reg) begin
                                stopped_next = 1'b1;
                            end
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                default: count_next = count_reg + CNT_W'(1);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= hpcp_pkg::PH_IDLE;
            op_first_reg  <= 8'd0;
            op_second_reg <= 8'd0;
            count_reg     <= '0;
            value_reg     <= 24'd0;
            prod_reg      <= 22'd0;
            negative_reg  <= 1'b0;
            active_reg    <= 1'b0;
            half_reg      <= 1'b0;
            held_x_reg    <= 16'd0;
            stopped_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            op_first_reg  <= op_first_next;
            op_second_reg <= op_second_next;
            count_reg     <= count_next;
            value_reg     <= value_next;
            prod_reg      <= prod_next;
            negative_reg  <= negative_next;
            active_reg    <= active_next;
            half_reg      <= half_next;
            held_x_reg    <= held_x_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

// ===== rtl/hpgl_command_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpgl_command_stream_parser
// Plotter command parser: characters in, pen moves, pressure and speed out.
// ----------------------------------------------------------------------------
// A character is accepted into an input register and decoded from there once
// the result queue has room for two results; its results (none, one, or two
// for the terminator of IN) are then written into the four-entry result
// queue, which presents them on the master side. The parser takes one
// character per cycle while the queue has room for two results, so the
// sustained rate is one character a cycle, bounded only by the result side
// draining one result a cycle. Coordinate scaling is carried alongside each
// argument as value times steps_per_mm, so a finished coordinate needs one
// divide-by-forty multiply in the decode cycle.
module hpgl_command_stream_parser #(
    parameter int MAX_COMMAND_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: steps_per_mm
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input characters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] action, [17:2] x_steps,
                                        // [33:18] y_steps, [42:34] amount, rest 0
    output logic        m_axis_tlast    // last result of a character
);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic [7:0]        steps_per_mm_reg;
    logic              core_fire;
    logic              room_two;
    hpcp_pkg::emit_t   emit;
    hpcp_pkg::result_t out_data;

    assign core_fire     = in_valid_reg && room_two;
    assign s_axis_tready = !in_valid_reg || core_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            steps_per_mm_reg <= hpcp_pkg::STEPS_PER_MM_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cfg_wr_en) begin
                steps_per_mm_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_char_reg <= s_axis_tdata;
        end
    end

    hpcp_core #(
        .MAX_COMMAND_LEN(MAX_COMMAND_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (core_fire),
        .char_code   (in_char_reg),
        .steps_per_mm(steps_per_mm_reg),
        .emit        (emit)
    );

    hpcp_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (emit),
        .push_en  (core_fire),
        .room_two (room_two),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_data)
    );

    assign m_axis_tdata = {5'd0, out_data.amount, out_data.y_steps, out_data.x_steps,
                           out_data.action};
    assign m_axis_tlast = out_data.last;

    // a character waiting in the input register is neither lost nor changed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !core_fire) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("input register dropped or changed a pending character");

    // anything decoded shows up on the result side in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (core_fire && emit.count != 2'd0) |=> m_axis_tvalid)
        else $error("decoded result not presented");

    // only the last result of a character carries the last flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (core_fire && emit.count == 2'd2) |-> (!emit.first.last && emit.second.last))
        else $error("last flag misplaced on a two-result character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (core_fire && emit.count == 2'd1) |-> emit.first.last)
        else $error("single result missing its last flag");

endmodule

// ===== dv/hpgl_command_stream_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpgl_command_stream_parser_tb
// Sends command characters to the plotter command parser and compares each
// result with its directed row or a bit-accurate parser model in the bench.
// The run starts with a table of short directed commands, then sends random
// command streams under several steps_per_mm settings. Both streams stall at
// random, and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module hpgl_command_stream_parser_tb;
    import hpcp_pkg::*;

    localparam int          MAX_CMD_LEN = 256;
    localparam int unsigned PHASE_CHARS = 300;
    localparam int          N_SETTINGS  = 6;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned RUN_LIMIT   = 1000000;
    localparam logic [23:0] ARG_SAT     = 24'hFFFFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [1:0] action, [17:2] x_steps,
                                        // [33:18] y_steps, [42:34] amount
    logic        m_axis_tlast;

    hpgl_command_stream_parser #(
        .MAX_COMMAND_LEN(MAX_CMD_LEN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser model state
    phase_t      cur_phase = PH_IDLE;
    logic [7:0]  op_first = 8'd0;
    logic [7:0]  op_second = 8'd0;
    int unsigned taken_count = 0;
    logic [23:0] arg_value = 24'd0;
    logic        arg_neg = 1'b0;
    logic        arg_active = 1'b0;
    logic        y_pending = 1'b0;
    logic [15:0] pair_x = 16'd0;
    logic        args_done = 1'b0;
    logic [7:0]  scale_spm = STEPS_PER_MM_RESET;

    result_t     char_actions[$];   // actions caused by the last character
    result_t     plot_queue[$];     // actions still to come out of the block
    logic [7:0]  cmd_bytes[$];

    int unsigned chars_sent = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned holds_done = 0;
    int unsigned cycle_count = 0;
    bit          hold_req = 1'b0;
    bit          sender_burst = 1'b0;

    function automatic result_t plot_action(input logic [1:0] a, input logic [15:0] x,
                                            input logic [15:0] y, input logic [8:0] amt,
                                            input logic lst);
        result_t r;
        r.action  = a;
        r.x_steps = x;
        r.y_steps = y;
        r.amount  = amt;
        r.last    = lst;
        return r;
    endfunction

    // directed commands; '@' in a row stands for a NUL byte, count -1 means
    // the row is checked against the model only
    typedef struct {
        string   text;
        int      count;
        result_t r0;
        result_t r1;
    } cmd_row_t;

    cmd_row_t dir_rows[$] = '{
        '{";", 0, '0, '0},
        '{"IN;", 2, plot_action(ACT_PRESS, 0, 0, 200, 0), plot_action(ACT_MOVE, 0, 0, 0, 1)},
        '{"sp;", 1, plot_action(ACT_PRESS, 0, 0, 300, 1), '0},
        '{"SP1;", 1, plot_action(ACT_PRESS, 0, 0, 200, 1), '0},
        '{"SP2;", 1, plot_action(ACT_PRESS, 0, 0, 100, 1), '0},
        '{"SP-3;", 1, plot_action(ACT_PRESS, 0, 0, 50, 1), '0},
        '{"VS;", 1, plot_action(ACT_SPEED, 0, 0, 100, 1), '0},
        '{"VS45;", 1, plot_action(ACT_SPEED, 0, 0, 10, 1), '0},
        '{"vS50;", 1, plot_action(ACT_SPEED, 0, 0, 10, 1), '0},
        '{"VS-5;", 1, plot_action(ACT_SPEED, 0, 0, 100, 1), '0},
        '{" \t PU0,0,65535,65535;", 2, plot_action(ACT_MOVE, 0, 0, 0, 1),
          plot_action(ACT_MOVE, 16'hFFFF, 16'hFFFF, 0, 1)},
        '{"pd1638,-4\015", 1, plot_action(ACT_DRAW, 1638, 0, 0, 1), '0},
        '{"PD99999999,7,3\n", 1, plot_action(ACT_DRAW, 16'hFFFF, 7, 0, 1), '0},
        '{"PU+,5;", 1, plot_action(ACT_MOVE, 0, 5, 0, 1), '0},
        '{"PD1,2X3,4;", 1, plot_action(ACT_DRAW, 1, 2, 0, 1), '0},
        '{"PU1-2;", 1, plot_action(ACT_MOVE, 1, 0, 0, 1), '0},
        '{"ZZ1,2;", 0, '0, '0},
        '{"P;", 0, '0, '0},
        '{"@PU1,2;", 0, '0, '0},
        '{"   \t;", 0, '0, '0},
        '{"SP2\3773;", 1, plot_action(ACT_PRESS, 0, 0, 100, 1), '0},
        '{"PD3 4\t5,6;", -1, '0, '0},
        '{"VS12,3;", -1, '0, '0},
        '{"IN5,6;", -1, '0, '0},
        '{"PU1,2@3,4;", -1, '0, '0}
    };

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) ? c - 8'd32 : c;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == CH_COMMA || c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [15:0] to_steps(input logic [23:0] v, input logic n);
        logic [63:0] s;
        if (n) return 16'd0;
        s = ({40'd0, v} * {56'd0, scale_spm}) / 64'd40;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void add_action(input logic [1:0] a, input logic [15:0] x,
                                       input logic [15:0] y, input logic [8:0] amt);
        char_actions.push_back(plot_action(a, x, y, amt, 1'b0));
    endfunction

    function automatic void clear_args();
        arg_value  = 24'd0;
        arg_neg    = 1'b0;
        arg_active = 1'b0;
        y_pending  = 1'b0;
        pair_x     = 16'd0;
        args_done  = 1'b0;
    endfunction

    function automatic void take_digit(input logic [3:0] d);
        if (arg_value > (ARG_SAT - 24'(d)) / 24'd10) begin
            arg_value = ARG_SAT;
        end else begin
            arg_value = arg_value * 24'd10 + 24'(d);
        end
    endfunction

    // close the coordinate in progress; the second one of a pair emits
    function automatic void end_coord();
        logic [15:0] s;
        if (!arg_active) return;
        arg_active = 1'b0;
        s = to_steps(arg_value, arg_neg);
        if (!y_pending) begin
            pair_x = s;
            y_pending = 1'b1;
            return;
        end
        y_pending = 1'b0;
        add_action(op_second == CH_D ? ACT_DRAW : ACT_MOVE, pair_x, s, 9'd0);
    endfunction

    function automatic void pair_char(input logic [7:0] c);
        if (is_sep(c)) begin
            end_coord();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            end_coord();
            arg_active = 1'b1;
            arg_value  = 24'd0;
            arg_neg    = (c == CH_MINUS);
        end else if (is_digit(c)) begin
            if (!arg_active) begin
                arg_active = 1'b1;
                arg_value  = 24'd0;
                arg_neg    = 1'b0;
            end
            take_digit(4'(c - CH_ZERO));
        end else begin
            end_coord();
            args_done = 1'b1;
        end
    endfunction

    function automatic void single_char(input logic [7:0] c);
        if (is_sep(c)) begin
            if (arg_active) args_done = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            if (arg_active) begin
                args_done = 1'b1;
            end else begin
                arg_active = 1'b1;
                arg_neg    = (c == CH_MINUS);
            end
        end else if (is_digit(c)) begin
            arg_active = 1'b1;
            take_digit(4'(c - CH_ZERO));
        end else begin
            args_done = 1'b1;
        end
    endfunction

    function automatic void end_command();
        logic       neg;
        logic [8:0] amt;
        longint     speed;
        case (cur_phase)
            PH_PAIRS: begin
                if (!args_done) end_coord();
            end
            PH_INIT: begin
                add_action(ACT_PRESS, 16'd0, 16'd0, 9'd200);
                add_action(ACT_MOVE, 16'd0, 16'd0, 9'd0);
            end
            PH_SINGLE: begin
                neg = arg_neg && arg_value != 24'd0;
                if (op_first == CH_S) begin
                    amt = 9'd50;
                    if (!neg && arg_value == 24'd0) amt = 9'd300;
                    else if (!neg && arg_value == 24'd1) amt = 9'd200;
                    else if (!neg && arg_value == 24'd2) amt = 9'd100;
                    add_action(ACT_PRESS, 16'd0, 16'd0, amt);
                end else begin
                    speed = neg ? 100 + 2 * longint'(arg_value)
                                : 100 - 2 * longint'(arg_value);
                    if (speed < 10) speed = 10;
                    if (speed > 100) speed = 100;
                    add_action(ACT_SPEED, 16'd0, 16'd0, 9'(speed));
                end
            end
            default: ;
        endcase
        cur_phase   = PH_IDLE;
        op_first    = 8'd0;
        op_second   = 8'd0;
        taken_count = 0;
        clear_args();
    endfunction

    // fills char_actions with what one character makes the parser emit
    function automatic void decode_char(input logic [7:0] c);
        result_t r;
        char_actions.delete();
        if (c == CH_SEMI || c == CH_CR || c == CH_LF) begin
            if (taken_count > 0) end_command();
        end else if (taken_count < MAX_CMD_LEN - 1) begin
            taken_count++;
            case (cur_phase)
                PH_IDLE: begin
                    if (c == CH_NUL) begin
                        cur_phase = PH_IGNORE;
                    end else if (c != CH_SPACE && c != CH_TAB) begin
                        op_first  = upcase(c);
                        cur_phase = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    op_second = upcase(c);
                    clear_args();
                    if (op_first == CH_I && op_second == CH_N) begin
                        cur_phase = PH_INIT;
                    end else if (op_first == CH_P && (op_second == CH_U || op_second == CH_D)) begin
                        cur_phase = PH_PAIRS;
                    end else if ((op_first == CH_S && op_second == CH_P) ||
                                 (op_first == CH_V && op_second == CH_S)) begin
                        cur_phase = PH_SINGLE;
                    end else begin
                        cur_phase = PH_IGNORE;
                    end
                end
                PH_PAIRS: begin
                    if (!args_done) pair_char(c);
                end
                PH_SINGLE: begin
                    if (!args_done) single_char(c);
                end
                default: ;
            endcase
        end
        if (char_actions.size() > 0) begin
            r = char_actions.pop_back();
            r.last = 1'b1;
            char_actions.push_back(r);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] maybe_lower(input logic [7:0] c);
        if (c >= CH_A_UP && c <= CH_Z_UP && $urandom_range(0, 3) == 0) return c + 8'd32;
        return c;
    endfunction

    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_Z_UP = 8'h5A;

    function automatic void push_arg(input int unsigned mag_hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) cmd_bytes.push_back(CH_MINUS);
        else if (r < 20) cmd_bytes.push_back(CH_PLUS);
        // now and then a sign or an empty slot with no digits
        if ($urandom_range(0, 19) == 0) return;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            push_text($sformatf("%0d", $urandom_range(0, mag_hi)));
        end else if (r < 93) begin
            push_text($sformatf("%0d", $urandom_range(0, 3000000)));
        end else begin
            push_text($sformatf("%0d%0d", $urandom_range(1000, 99999),
                                $urandom_range(10000, 99999)));
        end
    endfunction

    // one random command, mostly well formed
    function automatic void gen_command();
        int unsigned kind, nargs, mag, r;
        logic [7:0]  op1, op2;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                cmd_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
        end
        mag = 9999;
        nargs = $urandom_range(0, 6);
        if (kind < 40) begin
            op1 = CH_P;
            op2 = CH_U;
        end else if (kind < 72) begin
            op1 = CH_P;
            op2 = CH_D;
        end else if (kind < 78) begin
            op1 = CH_I;
            op2 = CH_N;
            nargs = $urandom_range(0, 2);
        end else if (kind < 87) begin
            op1 = CH_S;
            op2 = CH_P;
            nargs = $urandom_range(0, 2);
            mag = 4;
        end else if (kind < 95) begin
            op1 = CH_V;
            op2 = CH_S;
            nargs = $urandom_range(0, 2);
            mag = 70;
        end else begin
            op1 = 8'($urandom_range(8'h21, 8'h7E));
            op2 = 8'($urandom_range(8'h21, 8'h7E));
        end
        cmd_bytes.push_back(maybe_lower(op1));
        if ($urandom_range(0, 32) != 0) begin
            cmd_bytes.push_back(maybe_lower(op2));
            for (int i = 0; i < nargs; i++) begin
                if (i > 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) push_text(",");
                    else if (r < 82) push_text(" ");
                    else if (r < 92) push_text("\t");
                    else push_text(", ");
                end
                push_arg(mag);
            end
            // a stray byte ends the argument list early
            if ($urandom_range(0, 24) == 0) begin
                cmd_bytes.push_back($urandom_range(0, 3) == 0 ? CH_NUL
                                                              : 8'($urandom_range(8'h3C, 8'hFF)));
                push_arg(mag);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 70) cmd_bytes.push_back(CH_SEMI);
        else if (r < 82) cmd_bytes.push_back(CH_CR);
        else if (r < 94) cmd_bytes.push_back(CH_LF);
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit typed);
        int unsigned gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge aclk); while (!s_axis_tready);
        chars_sent++;
        decode_char(c);
        if (!typed) begin
            foreach (char_actions[i]) plot_queue.push_back(char_actions[i]);
        end
    endtask

    // stop sending and let every outstanding action drain
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (plot_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    logic [7:0] fixed_spm [4] = '{8'd1, 8'd255, 8'd0, 8'd40};

    initial begin
        bit          typed;
        logic [7:0]  c;
        logic [7:0]  new_spm;
        int unsigned sent_in_phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            typed = dir_rows[i].count >= 0;
            if (dir_rows[i].count > 0) plot_queue.push_back(dir_rows[i].r0);
            if (dir_rows[i].count > 1) plot_queue.push_back(dir_rows[i].r1);
            for (int k = 0; k < dir_rows[i].text.len(); k++) begin
                c = dir_rows[i].text[k];
                send_byte(c == "@" ? CH_NUL : c, typed);
            end
        end

        for (int p = 0; p < N_SETTINGS; p++) begin
            quiesce();
            new_spm = (p < 4) ? fixed_spm[p] : 8'($urandom_range(2, 254));
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= new_spm;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            scale_spm = new_spm;
            if (p == 1) hold_req = 1'b1;
            sent_in_phase = 0;
            if (p == 2 || p == 4) begin
                // longer than the command buffer: the tail is dropped
                cmd_bytes.delete();
                push_text("PD");
                while (cmd_bytes.size() < 300) push_text($sformatf("%0d,", $urandom_range(0, 999)));
                cmd_bytes.push_back(CH_SEMI);
                foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], 1'b0);
            end
            while (sent_in_phase < PHASE_CHARS) begin
                cmd_bytes.delete();
                gen_command();
                sender_burst = ($urandom_range(0, 9) == 0);
                foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], 1'b0);
                sent_in_phase += cmd_bytes.size();
            end
            // close any command left open before the next setting
            send_byte(CH_SEMI, 1'b0);
        end
        quiesce();

        $display("sent %0d characters: directed rows, then random commands at steps_per_mm",
                 chars_sent);
        $display("1, 255, 0, 40 and two random values; %0d results checked, %0d long hold-offs",
                 results_seen, holds_done);
        if (errors == 0) begin
            $display("hpgl_command_stream_parser_tb passed");
        end else begin
            $display("hpgl_command_stream_parser_tb failed");
        end
        $finish;
    end

    initial begin
        int unsigned gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 9) == 0 ? 80 : $urandom_range(1, 12)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.action  = m_axis_tdata[1:0];
            got.x_steps = m_axis_tdata[17:2];
            got.y_steps = m_axis_tdata[33:18];
            got.amount  = m_axis_tdata[42:34];
            got.last    = m_axis_tlast;
            results_seen++;
            if (plot_queue.size() == 0) begin
                $display("%0t: unexpected transaction: action %0d x %0d y %0d amount %0d last %0b",
                         $time, got.action, got.x_steps, got.y_steps, got.amount, got.last);
                errors++;
            end else begin
                want = plot_queue.pop_front();
                if (got !== want || m_axis_tdata[47:43] !== 5'd0) begin
                    $display("%0t: expected action %0d x %0d y %0d amount %0d last %0b", $time,
                             want.action, want.x_steps, want.y_steps, want.amount, want.last);
                    $display("%0t:   actual action %0d x %0d y %0d amount %0d last %0b pad %h",
                             $time, got.action, got.x_steps, got.y_steps, got.amount, got.last,
                             m_axis_tdata[47:43]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, plot_queue.size());
            $display("hpgl_command_stream_parser_tb failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/hpcp_pkg.sv
rtl/hpcp_result_fifo.sv
rtl/hpcp_core.sv
rtl/hpgl_command_stream_parser.sv
dv/hpgl_command_stream_parser_tb.sv
